/* src/kebd_pkg.sv */
// Package for the keyboard event buffer: sizes, opcodes, register indexes,
// the store command struct and the byte extraction helper.
// Depends on nothing; every other file but kebd_ram imports it.
`default_nettype none

package kebd_pkg;

	// Number of entries in each key store.
	localparam int STORE_DEPTH = 16;
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// Fixed field widths.
	localparam int KEY_W  = 9;
	localparam int WORD_W = 32;
	localparam int OFF_W  = 8;
	localparam int OP_W   = 3;

	// Offsets at or above this value read as zero.
	localparam logic [OFF_W-1:0] REG_SPAN = 8'd24;

	// Request opcodes.
	typedef enum logic [OP_W-1:0] {
		OP_KEY_DOWN   = 3'd0,
		OP_KEY_UP     = 3'd1,
		OP_WORD_READ  = 3'd2,
		OP_BYTE_READ  = 3'd3,
		OP_WORD_WRITE = 3'd4,
		OP_BYTE_WRITE = 3'd5
	} kebd_op_t;

	// Word register indexes (byte offset divided by four).
	localparam logic [2:0] REG_PRESS_IRQ     = 3'd0;
	localparam logic [2:0] REG_RELEASE_IRQ   = 3'd1;
	localparam logic [2:0] REG_PRESS_POP     = 3'd2;
	localparam logic [2:0] REG_RELEASE_POP   = 3'd3;
	localparam logic [2:0] REG_PRESS_COUNT   = 3'd4;
	localparam logic [2:0] REG_RELEASE_COUNT = 3'd5;

	// Command from the decoder to one key store.
	typedef struct packed {
		logic push;
		logic pop;
	} kebd_cmd_t;

	// Byte number sel of a word, zero-extended to a word.
	function automatic logic [WORD_W-1:0] byte_of(input logic [WORD_W-1:0] word,
			input logic [1:0] sel);
		logic [WORD_W-1:0] shifted;
		begin
			shifted = word >> {sel, 3'b000};
			byte_of = {{(WORD_W-8){1'b0}}, shifted[7:0]};
		end
	endfunction

endpackage

`default_nettype wire

/* src/kebd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependency; used for both key stores.
`default_nettype none

module kebd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when not reading.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/kebd_store.sv */
// One wrap-around key store: RAM, per-entry valid bits, head and saturating count.
// Depends on kebd_pkg and kebd_ram.
`default_nettype none

module kebd_store import kebd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kebd_cmd_t        cmd,
	input  wire logic [KEY_W-1:0] key,
	output logic      [KEY_W-1:0] pop_data,
	output logic      [CNT_W-1:0] count
);

	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic                   valid_s1;
	logic [IDX_W-1:0]       head_next;
	logic [IDX_W-1:0]       head_prev;
	logic [KEY_W-1:0]       ram_rdata;

	// Wrap-around neighbors of the head.
	assign head_next = (head_q == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? IDX_W'(STORE_DEPTH - 1) : head_q - 1'b1;

	kebd_ram #(
		.WIDTH(KEY_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(head_next),
		.wdata(key),
		.re   (cmd.pop),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// Head, count and entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.push) begin
			head_q             <= head_next;
			valid_q[head_next] <= 1'b1;
			if (count_q != CNT_W'(STORE_DEPTH)) begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.pop) begin
			head_q   <= head_prev;
			valid_s1 <= valid_q[head_q];
			if (count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data = valid_s1 ? ram_rdata : '0;
	assign count    = count_q;

endmodule

`default_nettype wire

/* src/key_event_buffer_device_core.sv */
// Keyboard event buffer: a non-pop result is registered in the cycle after
// acceptance; a pop passes the registered RAM read and ST_POP first. One
// request per cycle while the output is not stalled and no pop is in flight.
// Reset clears the interrupt numbers, heads, counts and entry valid bits at
// once; there is no clearing pass. Depends on kebd_pkg and kebd_store.
`default_nettype none

module key_event_buffer_device_core import kebd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [OFF_W-1:0]  offset,
	input  wire logic [WORD_W-1:0] write_data,
	input  wire logic [KEY_W-1:0]  key_code,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      read_data,
	output logic                   irq_valid,
	output logic [WORD_W-1:0]      irq_number
);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] read_data_q;
	logic              irq_valid_q;
	logic [WORD_W-1:0] irq_number_q;
	logic [WORD_W-1:0] press_irq_q;
	logic [WORD_W-1:0] release_irq_q;
	logic              pop_release_q;
	logic              pop_byte_q;
	logic [1:0]        byte_sel_q;

	logic              accept;
	logic              out_free;
	logic              in_range;
	logic [2:0]        widx;
	logic              rd_access;
	logic              is_byte_read;
	logic              push_press;
	logic              push_release;
	logic              pop_press;
	logic              pop_release;
	logic [WORD_W-1:0] reg_word;
	logic [WORD_W-1:0] imm_rd;
	logic [WORD_W-1:0] pop_word;
	logic [KEY_W-1:0]  press_pop_data;
	logic [KEY_W-1:0]  release_pop_data;
	logic [CNT_W-1:0]  press_count;
	logic [CNT_W-1:0]  release_count;
	kebd_cmd_t         press_cmd;
	kebd_cmd_t         release_cmd;

	// Handshake: requests wait while a pop or a stalled result is pending.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	// Request decode.
	assign in_range     = offset < REG_SPAN;
	assign widx         = offset[4:2];
	assign is_byte_read = opcode == OP_BYTE_READ;
	assign rd_access    = in_range &&
		((opcode == OP_WORD_READ && offset[1:0] == 2'b00) || is_byte_read);
	assign push_press   = accept && opcode == OP_KEY_DOWN && press_irq_q != '0;
	assign push_release = accept && opcode == OP_KEY_UP && release_irq_q != '0;
	assign pop_press    = accept && rd_access && widx == REG_PRESS_POP;
	assign pop_release  = accept && rd_access && widx == REG_RELEASE_POP;

	assign press_cmd   = '{push: push_press, pop: pop_press};
	assign release_cmd = '{push: push_release, pop: pop_release};

	kebd_store u_press (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (press_cmd),
		.key     (key_code),
		.pop_data(press_pop_data),
		.count   (press_count)
	);

	kebd_store u_release (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (release_cmd),
		.key     (key_code),
		.pop_data(release_pop_data),
		.count   (release_count)
	);

	// Word value of the registers that answer without a store read.
	always_comb begin
		unique case (widx)
			REG_PRESS_IRQ:     reg_word = press_irq_q;
			REG_RELEASE_IRQ:   reg_word = release_irq_q;
			REG_PRESS_COUNT:   reg_word = WORD_W'(press_count);
			REG_RELEASE_COUNT: reg_word = WORD_W'(release_count);
			default:           reg_word = '0;
		endcase
	end

	assign imm_rd = !rd_access ? '0 :
		(is_byte_read ? byte_of(reg_word, offset[1:0]) : reg_word);

	// Popped entry, selected from the store that was read.
	always_comb begin
		pop_word = WORD_W'(pop_release_q ? release_pop_data : press_pop_data);
		if (pop_byte_q) begin
			pop_word = byte_of(pop_word, byte_sel_q);
		end
	end

	// Interrupt number registers, written by word or byte writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_irq_q   <= '0;
			release_irq_q <= '0;
		end else if (accept) begin
			if (opcode == OP_WORD_WRITE) begin
				if (offset == {3'b000, REG_PRESS_IRQ, 2'b00}) begin
					press_irq_q <= write_data;
				end else if (offset == {3'b000, REG_RELEASE_IRQ, 2'b00}) begin
					release_irq_q <= write_data;
				end
			end else if (opcode == OP_BYTE_WRITE) begin
				if (offset[OFF_W-1:2] == {3'b000, REG_PRESS_IRQ}) begin
					press_irq_q[offset[1:0]*8 +: 8] <= write_data[7:0];
				end else if (offset[OFF_W-1:2] == {3'b000, REG_RELEASE_IRQ}) begin
					release_irq_q[offset[1:0]*8 +: 8] <= write_data[7:0];
				end
			end
		end
	end

	// Control state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			read_data_q   <= '0;
			irq_valid_q   <= 1'b0;
			irq_number_q  <= '0;
			pop_release_q <= 1'b0;
			pop_byte_q    <= 1'b0;
			byte_sel_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						if (pop_press || pop_release) begin
							pop_release_q <= pop_release;
							pop_byte_q    <= is_byte_read;
							byte_sel_q    <= offset[1:0];
							state_q       <= ST_POP;
						end else begin
							out_valid_q  <= 1'b1;
							read_data_q  <= imm_rd;
							irq_valid_q  <= push_press || push_release;
							irq_number_q <= push_press ? press_irq_q :
								(push_release ? release_irq_q : '0);
						end
					end
				end
				ST_POP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						read_data_q  <= pop_word;
						irq_valid_q  <= 1'b0;
						irq_number_q <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign irq_valid  = irq_valid_q;
	assign irq_number = irq_number_q;

endmodule

`default_nettype wire

/* src/kebd_checker.sv */
// Port-level checks for the keyboard event buffer, bound to its top level.
// Depends on kebd_pkg and key_event_buffer_device_core.
`default_nettype none

module kebd_checker import kebd_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [WORD_W-1:0] read_data,
	input wire logic              irq_valid,
	input wire logic [WORD_W-1:0] irq_number
);

	// An interrupt result never carries read data.
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && irq_valid) |-> read_data == '0)
		else $error("interrupt result carries read data");

	// Without an interrupt the number is zero.
	a_no_irq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !irq_valid) |-> irq_number == '0)
		else $error("interrupt number without interrupt");

	// A stored event is raised only with a nonzero number.
	a_irq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && irq_valid) |-> irq_number != '0)
		else $error("interrupt raised with number zero");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(read_data) && $stable(irq_valid) && $stable(irq_number)))
		else $error("stalled result changed");

endmodule

bind key_event_buffer_device_core kebd_checker u_kebd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data),
	.irq_valid (irq_valid),
	.irq_number(irq_number)
);

`default_nettype wire

/* verif/key_event_buffer_device_tb.sv */
// Self-checking testbench for key_event_buffer_device_core: directed and random
// key events and bus accesses, with a scoreboard that predicts every result.
// Depends on kebd_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
	import kebd_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 20;

	// One result of the block as seen on its output port.
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              irq_valid;
		logic [WORD_W-1:0] irq_number;
	} bus_result_t;

	// Mirror of both key stores and the interrupt registers, plus the queue of
	// results that accepted requests still owe.
	class key_store_mirror;
		logic [WORD_W-1:0] irq_num [2];
		logic [KEY_W-1:0]  keys [2][STORE_DEPTH];
		int                head [2];
		int                count [2];
		bus_result_t       due_results [$];
		int                errors;

		function new();
			irq_num = '{'0, '0};
			head    = '{0, 0};
			count   = '{0, 0};
			errors  = 0;
			foreach (keys[s, i]) keys[s][i] = '0;
		endfunction

		// Return the entry at the head, step the head back and shrink the count.
		function logic [WORD_W-1:0] pop_entry(int side);
			logic [WORD_W-1:0] v;
			v = WORD_W'(keys[side][head[side]]);
			head[side] = (head[side] + STORE_DEPTH - 1) % STORE_DEPTH;
			if (count[side] != 0) count[side]--;
			return v;
		endfunction

		// Word read of one register; unaligned and out-of-range offsets read zero.
		function logic [WORD_W-1:0] read_reg(logic [OFF_W-1:0] off);
			if (off[1:0] != 2'b00 || off >= REG_SPAN) return '0;
			case (off[4:2])
				REG_PRESS_IRQ:     return irq_num[0];
				REG_RELEASE_IRQ:   return irq_num[1];
				REG_PRESS_POP:     return pop_entry(0);
				REG_RELEASE_POP:   return pop_entry(1);
				REG_PRESS_COUNT:   return WORD_W'(count[0]);
				REG_RELEASE_COUNT: return WORD_W'(count[1]);
				default:           return '0;
			endcase
		endfunction

		// Apply one accepted request and queue its expected result.
		// Returns 1 when the request did anything beyond being ignored.
		function bit note_request(kebd_op_t op, logic [OFF_W-1:0] off,
				logic [WORD_W-1:0] wd, logic [KEY_W-1:0] key);
			bus_result_t       r;
			logic [WORD_W-1:0] w;
			int                side;
			bit                live;
			r = '0;
			live = 1'b0;
			case (op)
				OP_KEY_DOWN, OP_KEY_UP: begin
					side = (op == OP_KEY_UP) ? 1 : 0;
					if (irq_num[side] != '0) begin
						if (count[side] < STORE_DEPTH) count[side]++;
						head[side] = (head[side] + 1) % STORE_DEPTH;
						keys[side][head[side]] = key;
						r.irq_valid = 1'b1;
						r.irq_number = irq_num[side];
						live = 1'b1;
					end
				end
				OP_WORD_READ: begin
					live = (off[1:0] == 2'b00 && off < REG_SPAN);
					r.read_data = read_reg(off);
				end
				OP_BYTE_READ: begin
					if (off < REG_SPAN) begin
						w = read_reg({off[OFF_W-1:2], 2'b00});
						r.read_data = {24'b0, w[off[1:0]*8 +: 8]};
						live = 1'b1;
					end
				end
				OP_WORD_WRITE: begin
					if (off == {REG_PRESS_IRQ, 2'b00}) begin
						irq_num[0] = wd;
						live = 1'b1;
					end else if (off == {REG_RELEASE_IRQ, 2'b00}) begin
						irq_num[1] = wd;
						live = 1'b1;
					end
				end
				OP_BYTE_WRITE: begin
					// The press number and the release number take byte writes.
					if (off[OFF_W-1:2] == {3'b000, REG_PRESS_IRQ} ||
							off[OFF_W-1:2] == {3'b000, REG_RELEASE_IRQ}) begin
						side = off[2] ? 1 : 0;
						irq_num[side][off[1:0]*8 +: 8] = wd[7:0];
						live = 1'b1;
					end
				end
				default: ;
			endcase
			due_results.push_back(r);
			return live;
		endfunction

		function void report(string field, logic [WORD_W-1:0] exp_v,
				logic [WORD_W-1:0] act_v);
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, field,
				exp_v, act_v);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(logic [WORD_W-1:0] rd, logic iv,
				logic [WORD_W-1:0] irqn);
			bus_result_t e;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending, expected none actual %h",
					$time, rd);
				return;
			end
			e = due_results.pop_front();
			if (rd !== e.read_data) report("read_data", e.read_data, rd);
			if (iv !== e.irq_valid) report("irq_valid", WORD_W'(e.irq_valid), WORD_W'(iv));
			if (irqn !== e.irq_number) report("irq_number", e.irq_number, irqn);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   opcode = '0;
	logic [OFF_W-1:0]  offset = '0;
	logic [WORD_W-1:0] write_data = '0;
	logic [KEY_W-1:0]  key_code = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] read_data;
	logic              irq_valid;
	logic [WORD_W-1:0] irq_number;

	key_store_mirror mirror = new();
	int              live_items = 0;
	int              quiet_cycles = 0;

	key_event_buffer_device_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.offset     (offset),
		.write_data (write_data),
		.key_code   (key_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.irq_valid  (irq_valid),
		.irq_number (irq_number)
	);

	always #1 clk = ~clk;

	// Gap length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Interrupt number to program: sometimes zero so that events get dropped.
	function automatic logic [WORD_W-1:0] irq_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	// Present one request, hold it until accepted, then record it.
	task automatic send_request(input kebd_op_t op, input logic [OFF_W-1:0] off,
			input logic [WORD_W-1:0] wd, input logic [KEY_W-1:0] key, input bit hurry);
		int gap;
		gap = hurry ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		offset     <= off;
		write_data <= wd;
		key_code   <= key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (mirror.note_request(op, off, wd, key)) live_items++;
	endtask

	// Result side: check every accepted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.check_result(read_data, irq_valid, irq_number);
	end

	// Result side back-pressure: stall bursts between free stretches.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 4)) @(posedge clk);
		end
	end

	// Watchdog: too long without any request or result moving ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	// Stimulus: directed requests, then random episodes.
	initial begin
		kebd_op_t         op;
		logic [OFF_W-1:0] off;
		logic [WORD_W-1:0] wd;
		logic [KEY_W-1:0] key;
		int               mode;
		int               len;
		int               pick;
		bit               hurry;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pops of empty stores, and events dropped while the numbers are zero.
		send_request(OP_WORD_READ, 8'd8, $urandom, 9'h1FF, 1'b0);
		send_request(OP_BYTE_READ, 8'd13, $urandom, 9'h000, 1'b0);
		send_request(OP_KEY_DOWN, 8'd0, $urandom, 9'h1FF, 1'b0);
		send_request(OP_KEY_UP, 8'd255, $urandom, 9'h0AA, 1'b0);
		// Program the numbers by word and by bytes; ignored write offsets.
		send_request(OP_WORD_WRITE, 8'd0, 32'hFFFF_FFFF, 9'h000, 1'b0);
		send_request(OP_BYTE_WRITE, 8'd4, 32'h1234_56A5, 9'h000, 1'b0);
		send_request(OP_BYTE_WRITE, 8'd7, 32'hFFFF_FF80, 9'h000, 1'b0);
		send_request(OP_WORD_WRITE, 8'd8, 32'hDEAD_BEEF, 9'h000, 1'b0);
		send_request(OP_BYTE_WRITE, 8'd255, 32'hFFFF_FFFF, 9'h1FF, 1'b0);
		// Stored events, then counts and numbers read back.
		send_request(OP_KEY_DOWN, 8'd0, 32'h0, 9'h1FF, 1'b0);
		send_request(OP_KEY_DOWN, 8'd0, 32'h0, 9'h000, 1'b0);
		send_request(OP_KEY_UP, 8'd0, 32'h0, 9'h155, 1'b0);
		send_request(OP_WORD_READ, 8'd16, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_READ, 8'd20, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_READ, 8'd0, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_READ, 8'd4, 32'h0, 9'h0, 1'b0);
		// Unaligned and out-of-range reads.
		send_request(OP_WORD_READ, 8'd2, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_READ, 8'd24, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_READ, 8'd252, 32'h0, 9'h0, 1'b0);
		send_request(OP_BYTE_READ, 8'd255, 32'h0, 9'h0, 1'b0);
		// Byte reads of a number and of the pop ports, a word pop, then the release number cleared.
		send_request(OP_BYTE_READ, 8'd3, 32'h0, 9'h0, 1'b0);
		send_request(OP_BYTE_READ, 8'd9, 32'h0, 9'h0, 1'b0);
		send_request(OP_BYTE_READ, 8'd14, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_READ, 8'd8, 32'h0, 9'h0, 1'b0);
		send_request(OP_WORD_WRITE, 8'd4, 32'h0, 9'h0, 1'b0);

		// Random episodes, each of one flavor of traffic.
		while (live_items < ITEM_TARGET) begin
			mode  = $urandom_range(0, 9);
			hurry = ($urandom_range(0, 3) == 0);
			len   = $urandom_range(4, 30);
			repeat (len) begin
				op  = OP_WORD_READ;
				off = OFF_W'($urandom_range(0, 23));
				wd  = $urandom;
				key = KEY_W'($urandom_range(0, 511));
				pick = $urandom_range(0, 9);
				case (mode)
					// Fill one store, often past full.
					3, 4: begin
						if (pick == 0) begin
							off = OFF_W'($urandom_range(2, 5) * 4);
						end else begin
							op = (mode == 3) ? OP_KEY_DOWN : OP_KEY_UP;
						end
					end
					// Drain through the pop ports, by words (with count reads) or by bytes.
					5, 6: begin
						if (pick < 2) begin
							op = pick[0] ? OP_KEY_UP : OP_KEY_DOWN;
						end else if (mode == 5) begin
							off = OFF_W'($urandom_range(2, 5) * 4);
						end else begin
							op  = OP_BYTE_READ;
							off = OFF_W'($urandom_range(8, 15));
						end
					end
					// Reprogram and read back the interrupt numbers.
					7: begin
						off = OFF_W'($urandom_range(0, 7));
						if (pick < 4) begin
							op  = OP_WORD_WRITE;
							off = {off[2], 2'b00};
							wd  = irq_value();
						end else if (pick < 7) begin
							op = OP_BYTE_WRITE;
							wd = (pick == 4) ? 32'h0 : wd;
						end else if (pick < 9) begin
							op = OP_BYTE_READ;
						end else begin
							off = {off[2], 2'b00};
						end
					end
					// Anything at any offset.
					8: begin
						op  = kebd_op_t'($urandom_range(0, 5));
						off = OFF_W'($urandom_range(0, 255));
					end
					// Mixed traffic.
					default: begin
						if (pick < 4) begin
							op = pick[0] ? OP_KEY_UP : OP_KEY_DOWN;
						end else if (pick < 7) begin
							off = OFF_W'($urandom_range(0, 5) * 4);
						end else if (pick == 7) begin
							op = OP_BYTE_READ;
						end else if (pick == 8) begin
							op  = OP_WORD_WRITE;
							off = OFF_W'($urandom_range(0, 1) * 4);
							wd  = irq_value();
						end else begin
							op  = OP_BYTE_WRITE;
							off = OFF_W'($urandom_range(0, 7));
						end
					end
				endcase
				send_request(op, off, wd, key, hurry);
			end
		end

		// Wait for every outstanding result, then a little longer for strays.
		in_valid <= 1'b0;
		while (mirror.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mirror.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
src/kebd_pkg.sv
src/kebd_ram.sv
src/kebd_store.sv
src/key_event_buffer_device_core.sv
src/kebd_checker.sv
verif/key_event_buffer_device_tb.sv
